### sv/sobel_pkg.sv
// shared types, constants and helpers for the sobel edge highlight pipeline
// no dependencies
package sobel_pkg;

    localparam logic       OP_PIXEL        = 1'b0;
    localparam logic       OP_FLUSH        = 1'b1;

    localparam logic       REG_FRAME_WIDTH  = 1'b0;
    localparam logic       REG_FRAME_HEIGHT = 1'b1;

    localparam logic [11:0] WIDTH_RESET    = 12'd640;
    localparam logic [11:0] HEIGHT_RESET   = 12'd480;
    localparam logic [11:0] MIN_DIM        = 12'd3;

    localparam logic [7:0] ALPHA_OPAQUE    = 8'hFF;
    localparam logic [7:0] CHAN_MAX        = 8'd255;
    localparam int         EDGE_GAIN       = 10;

    localparam int         FIFO_DEPTH      = 8;
    localparam int         FIFO_AW         = $clog2(FIFO_DEPTH);

    // per request control carried from the front to the core
    typedef struct packed {
        logic upd;      // pixel updates window, lines and colour delay
        logic emit;     // request produces a result
        logic border;   // result is black
        logic last;     // final result of the frame
    } sobel_ctl_t;

    // one finished result pixel
    typedef struct packed {
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
        logic       last;
    } sobel_pix_t;

    // exact x / 255 for x up to 255 * 255
    function automatic logic [7:0] div255(input logic [15:0] x);
        logic [16:0] t;
        t = {1'b0, x} + {9'd0, x[15:8]} + 17'd1;
        return t[15:8];
    endfunction

endpackage

### sv/sobel_ram.sv
// generic single write port ram with registered read-first read port
// no dependencies
module sobel_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2048,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

endmodule

### sv/sobel_front.sv
// front end: config registers, frame counters and request classification
// depends on sobel_pkg
module sobel_front import sobel_pkg::*; #(
    parameter int MAX_WIDTH = 2048,
    localparam int CW = $clog2(MAX_WIDTH),
    localparam int WW = $clog2(MAX_WIDTH + 1)
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cfg_we,
    input  logic          cfg_index,
    input  logic [11:0]   cfg_data,
    input  logic          accept,
    input  logic          op,
    input  logic [7:0]    in_blue,
    input  logic [7:0]    in_green,
    input  logic [7:0]    in_red,
    output logic [CW-1:0] rd_col,
    output logic [WW-1:0] rd_ptr,
    output sobel_ctl_t    ctl_reg,
    output logic [CW-1:0] wr_col_reg,
    output logic [WW-1:0] wr_ptr_reg,
    output logic [7:0]    luma_reg,
    output logic [23:0]   rgb_reg
);

    logic [11:0]   width_reg, height_reg;
    logic [CW-1:0] col_reg, col_next;
    logic [11:0]   row_reg, row_next;
    logic [WW-1:0] ptr_reg, ptr_next;
    logic [CW-1:0] ocol_reg, ocol_next;
    logic [11:0]   orow_reg, orow_next;
    logic [WW-1:0] w_eff;
    logic [11:0]   h_eff;
    logic          pixel, flush_emit, started, emit, border, last;
    logic [9:0]    luma_sum;

    always_comb
    begin
        if (width_reg < MIN_DIM)
            w_eff = WW'(MIN_DIM);
        else if (int'(width_reg) > MAX_WIDTH)
            w_eff = WW'(MAX_WIDTH);
        else
            w_eff = WW'(width_reg);
        h_eff = (height_reg < MIN_DIM) ? MIN_DIM : height_reg;
    end

    assign pixel      = accept && (op == OP_PIXEL) && (row_reg < h_eff);
    assign flush_emit = accept && (op == OP_FLUSH) && (row_reg >= h_eff);
    assign started    = (row_reg > 12'd1) || ((row_reg == 12'd1) && (col_reg != '0));
    assign emit       = (pixel && started) || flush_emit;
    assign border     = (orow_reg == 12'd0) || (orow_reg >= h_eff - 12'd1)
                     || (ocol_reg == '0) || (int'(ocol_reg) + 1 >= int'(w_eff));
    assign last       = (orow_reg == h_eff - 12'd1) && (int'(ocol_reg) + 1 == int'(w_eff));
    assign luma_sum   = {2'd0, in_red} + {1'b0, in_green, 1'b0} + {2'd0, in_blue};

    assign rd_col = col_reg;
    assign rd_ptr = ptr_reg;

    always_comb
    begin
        col_next  = col_reg;
        row_next  = row_reg;
        ptr_next  = ptr_reg;
        ocol_next = ocol_reg;
        orow_next = orow_reg;
        if (pixel)
        begin
            if (int'(col_reg) + 1 >= int'(w_eff))
            begin
                col_next = '0;
                row_next = row_reg + 12'd1;
            end
            else
            begin
                col_next = col_reg + CW'(1);
            end
            ptr_next = (ptr_reg >= w_eff) ? '0 : ptr_reg + WW'(1);
        end
        if (emit)
        begin
            if (int'(ocol_reg) + 1 >= int'(w_eff))
            begin
                ocol_next = '0;
                orow_next = orow_reg + 12'd1;
            end
            else
            begin
                ocol_next = ocol_reg + CW'(1);
            end
        end
        // frame restart on config write or after the final result
        if (cfg_we || (emit && last))
        begin
            col_next  = '0;
            row_next  = '0;
            ptr_next  = '0;
            ocol_next = '0;
            orow_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
            col_reg    <= '0;
            row_reg    <= '0;
            ptr_reg    <= '0;
            ocol_reg   <= '0;
            orow_reg   <= '0;
            ctl_reg    <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_FRAME_WIDTH:  width_reg  <= cfg_data;
                    REG_FRAME_HEIGHT: height_reg <= cfg_data;
                    default:          ;
                endcase
            end
            col_reg  <= col_next;
            row_reg  <= row_next;
            ptr_reg  <= ptr_next;
            ocol_reg <= ocol_next;
            orow_reg <= orow_next;
            ctl_reg  <= '{upd: pixel, emit: emit, border: border, last: last};
        end
    end

    always_ff @(posedge clk)
    begin
        wr_col_reg <= col_reg;
        wr_ptr_reg <= ptr_reg;
        luma_reg   <= luma_sum[9:2];
        rgb_reg    <= {in_red, in_green, in_blue};
    end

endmodule

### sv/sobel_core.sv
// core: line buffers, colour delay, 3x3 window, sobel and colour scaling
// depends on sobel_pkg and sobel_ram
module sobel_core import sobel_pkg::*; #(
    parameter int MAX_WIDTH = 2048,
    localparam int CW = $clog2(MAX_WIDTH),
    localparam int WW = $clog2(MAX_WIDTH + 1)
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic [CW-1:0] rd_col,
    input  logic [WW-1:0] rd_ptr,
    input  sobel_ctl_t    ctl,
    input  logic [CW-1:0] wr_col,
    input  logic [WW-1:0] wr_ptr,
    input  logic [7:0]    luma,
    input  logic [23:0]   rgb,
    output logic          push_valid_reg,
    output sobel_pix_t    push_pix_reg,
    output logic [1:0]    busy
);

    logic [7:0]  l0_q, l1_q;
    logic [23:0] c_q;
    logic [7:0]  win_reg [9];
    logic [7:0]  win_next [9];
    logic [9:0]  sa, sb, sc, sd, dh_raw, dv_raw;
    logic [6:0]  dh, dv;
    logic [7:0]  e;
    logic [11:0] v10;
    logic [7:0]  v;
    logic        s2_valid_reg, s2_border_reg, s2_last_reg;
    logic [7:0]  s2_v_reg;
    logic [23:0] s2_rgb_reg;

    sobel_ram #(.WIDTH(8), .DEPTH(MAX_WIDTH)) u_line0 (
        .clk(clk), .we(ctl.upd), .waddr(wr_col), .wdata(l1_q),
        .raddr(rd_col), .rdata(l0_q)
    );

    sobel_ram #(.WIDTH(8), .DEPTH(MAX_WIDTH)) u_line1 (
        .clk(clk), .we(ctl.upd), .waddr(wr_col), .wdata(luma),
        .raddr(rd_col), .rdata(l1_q)
    );

    sobel_ram #(.WIDTH(24), .DEPTH(MAX_WIDTH + 1)) u_cdelay (
        .clk(clk), .we(ctl.upd), .waddr(wr_ptr), .wdata(rgb),
        .raddr(rd_ptr), .rdata(c_q)
    );

    always_comb
    begin
        win_next[0] = win_reg[1];
        win_next[1] = win_reg[2];
        win_next[2] = l0_q;
        win_next[3] = win_reg[4];
        win_next[4] = win_reg[5];
        win_next[5] = l1_q;
        win_next[6] = win_reg[7];
        win_next[7] = win_reg[8];
        win_next[8] = luma;
    end

    always_comb
    begin
        sa = {2'd0, win_next[6]} + {1'b0, win_next[7], 1'b0} + {2'd0, win_next[8]};
        sb = {2'd0, win_next[0]} + {1'b0, win_next[1], 1'b0} + {2'd0, win_next[2]};
        sc = {2'd0, win_next[2]} + {1'b0, win_next[5], 1'b0} + {2'd0, win_next[8]};
        sd = {2'd0, win_next[0]} + {1'b0, win_next[3], 1'b0} + {2'd0, win_next[6]};
        dh_raw = (sa >= sb) ? sa - sb : sb - sa;
        dv_raw = (sc >= sd) ? sc - sd : sd - sc;
        dh = dh_raw[9:3];
        dv = dv_raw[9:3];
        e  = {1'b0, dh} + {1'b0, dv};
        v10 = 12'(e) * 12'(EDGE_GAIN);
        v  = (v10 > 12'(CHAN_MAX)) ? CHAN_MAX : v10[7:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 9; i++)
            begin
                win_reg[i] <= '0;
            end
            s2_valid_reg   <= 1'b0;
            push_valid_reg <= 1'b0;
        end
        else
        begin
            if (ctl.upd)
            begin
                for (int i = 0; i < 9; i++)
                begin
                    win_reg[i] <= win_next[i];
                end
            end
            s2_valid_reg   <= ctl.emit;
            push_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s2_border_reg <= ctl.border;
        s2_last_reg   <= ctl.last;
        s2_v_reg      <= v;
        s2_rgb_reg    <= c_q;
        push_pix_reg.last <= s2_last_reg;
        if (s2_border_reg)
        begin
            push_pix_reg.blue  <= '0;
            push_pix_reg.green <= '0;
            push_pix_reg.red   <= '0;
        end
        else
        begin
            push_pix_reg.blue  <= div255(16'(s2_v_reg) * 16'(s2_rgb_reg[7:0]));
            push_pix_reg.green <= div255(16'(s2_v_reg) * 16'(s2_rgb_reg[15:8]));
            push_pix_reg.red   <= div255(16'(s2_v_reg) * 16'(s2_rgb_reg[23:16]));
        end
    end

    assign busy = {1'b0, s2_valid_reg} + {1'b0, push_valid_reg};

endmodule

### sv/sobel_fifo.sv
// small result queue between the core and the output port
// depends on sobel_pkg
module sobel_fifo import sobel_pkg::*; (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  sobel_pix_t       push_pix,
    input  logic             pop,
    output logic             not_empty,
    output sobel_pix_t       head,
    output logic [FIFO_AW:0] count
);

    sobel_pix_t           mem_reg [FIFO_DEPTH];
    logic [FIFO_AW-1:0]   wp_reg, rp_reg;
    logic [FIFO_AW:0]     count_reg;
    logic                 do_pop;

    assign do_pop    = pop && (count_reg != '0);
    assign not_empty = (count_reg != '0);
    assign head      = mem_reg[rp_reg];
    assign count     = count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg    <= '0;
            rp_reg    <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wp_reg <= wp_reg + FIFO_AW'(1);
            end
            if (do_pop)
            begin
                rp_reg <= rp_reg + FIFO_AW'(1);
            end
            count_reg <= count_reg + (FIFO_AW + 1)'(push) - (FIFO_AW + 1)'(do_pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wp_reg] <= push_pix;
        end
    end

endmodule

### sv/sobel_edge_highlight_pipeline.sv
// sobel edge highlight, top level: front, core pipeline and result queue
// depends on sobel_pkg, sobel_front, sobel_core, sobel_fifo, sobel_ram
// throughput: one request per cycle while the result queue has room
// a result passes the front's control register, the core's s2 and push registers and the result queue
// results trail pixels by one line plus one pixel; flush requests drain that lag
// reset: asynchronous active low, registers return to 640x480, counters and
// window to zero; line and colour memories are not cleared
module sobel_edge_highlight_pipeline import sobel_pkg::*; #(
    parameter int MAX_WIDTH = 2048
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [11:0] cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        op,
    input  logic [7:0]  in_blue,
    input  logic [7:0]  in_green,
    input  logic [7:0]  in_red,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  out_blue,
    output logic [7:0]  out_green,
    output logic [7:0]  out_red,
    output logic [7:0]  out_alpha,
    output logic        out_last
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int WW = $clog2(MAX_WIDTH + 1);

    logic              accept;
    logic [CW-1:0]     rd_col, wr_col;
    logic [WW-1:0]     rd_ptr, wr_ptr;
    sobel_ctl_t        ctl;
    logic [7:0]        luma;
    logic [23:0]       rgb;
    logic              push_valid;
    sobel_pix_t        push_pix, head;
    logic [1:0]        core_busy;
    logic [FIFO_AW:0]  q_count;
    logic [FIFO_AW+2:0] committed;

    // the core never stalls, so the front only takes a request when every
    // result already in flight is sure of a queue slot
    assign committed = (FIFO_AW + 3)'(q_count) + (FIFO_AW + 3)'(core_busy)
                     + (FIFO_AW + 3)'(ctl.emit);
    assign in_ready  = committed < (FIFO_AW + 3)'(FIFO_DEPTH);
    assign accept    = in_valid && in_ready;

    // front: counters, border and last classification, read addresses
    sobel_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .accept(accept), .op(op),
        .in_blue(in_blue), .in_green(in_green), .in_red(in_red),
        .rd_col(rd_col), .rd_ptr(rd_ptr),
        .ctl_reg(ctl), .wr_col_reg(wr_col), .wr_ptr_reg(wr_ptr),
        .luma_reg(luma), .rgb_reg(rgb)
    );

    // core: window update, gradients, colour scaling
    sobel_core #(.MAX_WIDTH(MAX_WIDTH)) u_core (
        .clk(clk), .rst_n(rst_n),
        .rd_col(rd_col), .rd_ptr(rd_ptr),
        .ctl(ctl), .wr_col(wr_col), .wr_ptr(wr_ptr),
        .luma(luma), .rgb(rgb),
        .push_valid_reg(push_valid), .push_pix_reg(push_pix),
        .busy(core_busy)
    );

    // result queue decouples the output handshake from the pipeline
    sobel_fifo u_fifo (
        .clk(clk), .rst_n(rst_n),
        .push(push_valid), .push_pix(push_pix),
        .pop(out_ready), .not_empty(out_valid),
        .head(head), .count(q_count)
    );

    assign out_blue  = head.blue;
    assign out_green = head.green;
    assign out_red   = head.red;
    assign out_last  = head.last;
    assign out_alpha = ALPHA_OPAQUE;

endmodule

### sv/sobel_checker.sv
// port level checks for the sobel edge highlight pipeline, bound to the top
// depends on sobel_pkg and sobel_edge_highlight_pipeline
module sobel_checker import sobel_pkg::*; (
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] out_blue,
    input logic [7:0] out_green,
    input logic [7:0] out_red,
    input logic [7:0] out_alpha,
    input logic       out_last
);

    // every result is opaque
    a_alpha: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_alpha == ALPHA_OPAQUE)
        else $error("alpha not opaque");

    // the final result lies in the corner, so it is black
    a_last_black: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_last |-> out_blue == 8'd0 && out_green == 8'd0 && out_red == 8'd0)
        else $error("last result not black");

    // a stalled result stays offered
    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped under stall");

    // a stalled result keeps its payload
    a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable({out_blue, out_green, out_red, out_last}))
        else $error("result changed under stall");

endmodule

bind sobel_edge_highlight_pipeline sobel_checker u_checker (.*);

### verif/sobel_edge_highlight_pipeline_tb.sv
// self-checking testbench for the sobel edge highlight pipeline
// depends on sobel_pkg and the rtl under sv/; holds its own predictor in a scoreboard class
`timescale 1ns / 100ps

module testbench;
    import sobel_pkg::*;

    localparam int MAX_W      = 2048;
    localparam int LAT_CYCLES = 12;
    localparam int CYCLE_CAP  = 1000000;

    // predictor plus store of expected result pixels
    class edge_scoreboard;
        byte unsigned luma_row[0:2*MAX_W-1];
        byte unsigned win[0:8];
        int unsigned  colour_hist[0:MAX_W];
        int unsigned  hist_ptr, col_pos, row_pos, sent_cnt;
        int unsigned  reg_width, reg_height;
        sobel_pix_t   expected_pix[$];
        int           errors;

        function new();
            foreach (luma_row[i]) luma_row[i] = 0;
            foreach (win[i]) win[i] = 0;
            foreach (colour_hist[i]) colour_hist[i] = 0;
            reg_width  = WIDTH_RESET;
            reg_height = HEIGHT_RESET;
            errors     = 0;
            restart();
        endfunction

        function void restart();
            hist_ptr = 0;
            col_pos  = 0;
            row_pos  = 0;
            sent_cnt = 0;
        endfunction

        function void write_reg(logic idx, logic [11:0] val);
            if (idx == REG_FRAME_WIDTH) reg_width = val;
            else reg_height = val;
            restart();
        endfunction

        function int pending();
            return expected_pix.size();
        endfunction

        function void push_pixel(int unsigned colour, int unsigned total);
            sobel_pix_t p;
            p.blue  = colour[7:0];
            p.green = colour[15:8];
            p.red   = colour[23:16];
            sent_cnt++;
            p.last  = (sent_cnt >= total);
            expected_pix.push_back(p);
            if (p.last) restart();
        endfunction

        // one accepted request: work out the result it causes, if any
        function void note_request(logic o, logic [7:0] b, logic [7:0] g, logic [7:0] r);
            int unsigned w, h, total, y, c, n, old, orow, ocol, dh, dv, e, v, pos, neg, scaled;
            w = reg_width < 3 ? 3 : (reg_width > MAX_W ? MAX_W : reg_width);
            h = reg_height < 3 ? 3 : reg_height;
            total = w * h;
            if (o == OP_FLUSH) begin
                // flush only drains once the frame's pixels are all in
                if (row_pos >= h && sent_cnt < total) push_pixel(0, total);
                return;
            end
            if (row_pos >= h) return;
            y = (r + 2 * g + b) / 4;
            c = col_pos;
            for (int k = 0; k < 3; k++) begin
                win[k*3]   = win[k*3+1];
                win[k*3+1] = win[k*3+2];
            end
            win[2] = luma_row[c];
            win[5] = luma_row[MAX_W + c];
            win[8] = 8'(y);
            luma_row[c] = luma_row[MAX_W + c];
            luma_row[MAX_W + c] = 8'(y);
            old = colour_hist[hist_ptr];
            colour_hist[hist_ptr] = {8'd0, r, g, b};
            hist_ptr = (hist_ptr >= w) ? 0 : hist_ptr + 1;
            n = row_pos * w + c;
            col_pos = c + 1;
            if (col_pos >= w) begin
                col_pos = 0;
                row_pos++;
            end
            if (n < w + 1) return;
            orow = sent_cnt / w;
            ocol = sent_cnt % w;
            if (orow == 0 || orow + 1 >= h || ocol == 0 || ocol + 1 >= w) begin
                push_pixel(0, total);
                return;
            end
            pos = win[6] + 2 * win[7] + win[8];
            neg = win[0] + 2 * win[1] + win[2];
            dh  = (pos >= neg ? pos - neg : neg - pos) / 8;
            pos = win[2] + 2 * win[5] + win[8];
            neg = win[0] + 2 * win[3] + win[6];
            dv  = (pos >= neg ? pos - neg : neg - pos) / 8;
            e = dh + dv;
            if (e > 255) e = 255;
            v = e * EDGE_GAIN;
            if (v > 255) v = 255;
            scaled = (v * (old & 8'hFF)) / 255
                   | ((v * ((old >> 8) & 8'hFF)) / 255) << 8
                   | ((v * ((old >> 16) & 8'hFF)) / 255) << 16;
            push_pixel(scaled, total);
        endfunction

        function void check_result(logic [7:0] b, logic [7:0] g, logic [7:0] r,
                                   logic [7:0] a, logic l);
            sobel_pix_t p;
            if (expected_pix.size() == 0) begin
                $error("result with nothing expected: b=%0d g=%0d r=%0d", b, g, r);
                errors++;
                return;
            end
            p = expected_pix.pop_front();
            if (b !== p.blue) begin
                $error("out_blue expected %0d actual %0d", p.blue, b);
                errors++;
            end
            if (g !== p.green) begin
                $error("out_green expected %0d actual %0d", p.green, g);
                errors++;
            end
            if (r !== p.red) begin
                $error("out_red expected %0d actual %0d", p.red, r);
                errors++;
            end
            if (a !== ALPHA_OPAQUE) begin
                $error("out_alpha expected %0d actual %0d", ALPHA_OPAQUE, a);
                errors++;
            end
            if (l !== p.last) begin
                $error("out_last expected %0d actual %0d", p.last, l);
                errors++;
            end
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic        cfg_index = 1'b0;
    logic [11:0] cfg_data = '0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic        op = OP_PIXEL;
    logic [7:0]  in_blue = '0;
    logic [7:0]  in_green = '0;
    logic [7:0]  in_red = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [7:0]  out_blue, out_green, out_red, out_alpha;
    logic        out_last;

    edge_scoreboard sb = new();
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int accepted = 0;
    int cycles = 0;

    sobel_edge_highlight_pipeline #(.MAX_WIDTH(MAX_W)) uut (.*);

    always #5 clk = ~clk;

    // run guard: a stuck handshake ends here
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_CAP)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // result side: check on each accepted result, stall at random
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
                sb.check_result(out_blue, out_green, out_red, out_alpha, out_last);
            out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // present one request and hold it until accepted
    task automatic send_request(logic o, logic [7:0] b, logic [7:0] g, logic [7:0] r);
        if ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        in_valid <= 1'b1;
        op       <= o;
        in_blue  <= b;
        in_green <= g;
        in_red   <= r;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        sb.note_request(o, b, g, r);
        accepted++;
    endtask

    task automatic send_pixel(logic [7:0] b, logic [7:0] g, logic [7:0] r);
        send_request(OP_PIXEL, b, g, r);
    endtask

    task automatic send_flush();
        send_request(OP_FLUSH, 8'($urandom_range(255)), 8'($urandom_range(255)),
                     8'($urandom_range(255)));
    endtask

    // drain: every expected result in, then the pipeline latency for ignored requests
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (sb.pending() > 0) @(posedge clk);
        repeat (LAT_CYCLES) @(posedge clk);
    endtask

    // register write, only from idle
    task automatic write_reg(logic idx, logic [11:0] val);
        wait_idle();
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        sb.write_reg(idx, val);
    endtask

    // random pixel biased toward flat areas and hard steps so edges show up
    task automatic send_random_pixel();
        case ($urandom_range(3))
            0: send_pixel(8'd0, 8'd0, 8'd0);
            1: send_pixel(8'd255, 8'd255, 8'd255);
            default: send_pixel(8'($urandom_range(255)), 8'($urandom_range(255)),
                                8'($urandom_range(255)));
        endcase
    endtask

    // one frame with random content; noise adds ignored flushes and extra pixels,
    // an aborted frame stops early and the next register write restarts it
    task automatic run_frame(logic [11:0] wreg, logic [11:0] hreg, int noise_pct);
        int unsigned w, h, npix, stop_at;
        w = wreg < 3 ? 3 : (wreg > MAX_W ? MAX_W : wreg);
        h = hreg < 3 ? 3 : hreg;
        npix = w * h;
        stop_at = ($urandom_range(99) < noise_pct) ? $urandom_range(1, npix) : npix + 1;
        write_reg(REG_FRAME_WIDTH, wreg);
        write_reg(REG_FRAME_HEIGHT, hreg);
        for (int unsigned i = 0; i < npix; i++)
        begin
            if (i == stop_at) return;
            if ($urandom_range(99) < noise_pct) send_flush();
            send_random_pixel();
        end
        for (int unsigned i = 0; i <= w; i++)
        begin
            if ($urandom_range(99) < noise_pct) send_random_pixel();
            send_flush();
        end
        if ($urandom_range(99) < noise_pct) send_flush();
    endtask

    task automatic random_phase(int target);
        int goal;
        logic [11:0] wv, hv;
        goal = accepted + target;
        while (accepted < goal)
        begin
            wv = $urandom_range(99) < 10 ? 12'($urandom_range(0, 2)) : 12'($urandom_range(3, 12));
            hv = $urandom_range(99) < 10 ? 12'($urandom_range(0, 2)) : 12'($urandom_range(3, 8));
            run_frame(wv, hv, $urandom_range(99) < 75 ? 0 : 15);
        end
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: smallest frame from out-of-range register values
        write_reg(REG_FRAME_WIDTH, 12'd0);
        write_reg(REG_FRAME_HEIGHT, 12'd1);
        send_flush();                               // early flush, ignored
        send_pixel(8'd0, 8'd0, 8'd0);
        send_pixel(8'd255, 8'd255, 8'd255);
        send_pixel(8'd0, 8'd0, 8'd0);
        send_pixel(8'd0, 8'd0, 8'd0);
        send_pixel(8'd255, 8'd128, 8'd1);           // the only interior pixel
        send_pixel(8'd255, 8'd255, 8'd255);
        send_pixel(8'd255, 8'd255, 8'd255);
        send_pixel(8'd0, 8'd0, 8'd0);
        send_pixel(8'd255, 8'd255, 8'd255);
        send_pixel(8'd10, 8'd20, 8'd30);            // extra pixel past the frame, ignored
        repeat (4) send_flush();
        send_flush();                               // nothing pending, ignored
        // 4x3 frame, flat then a strong step
        write_reg(REG_FRAME_WIDTH, 12'd4);
        write_reg(REG_FRAME_HEIGHT, 12'd3);
        for (int i = 0; i < 12; i++)
        begin
            if (i % 4 < 2) send_pixel(8'd0, 8'd0, 8'd0);
            else send_pixel(8'd255, 8'd255, 8'd255);
        end
        repeat (5) send_flush();

        send_idle_pct = 7;
        recv_idle_pct = 59;
        random_phase(250);
        send_idle_pct = 59;
        recv_idle_pct = 7;
        random_phase(250);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        random_phase(250);

        wait_idle();
        repeat (LAT_CYCLES) @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

### sobel_edge_highlight_pipeline.f
sv/sobel_pkg.sv
sv/sobel_ram.sv
sv/sobel_front.sv
sv/sobel_core.sv
sv/sobel_fifo.sv
sv/sobel_edge_highlight_pipeline.sv
sv/sobel_checker.sv
verif/sobel_edge_highlight_pipeline_tb.sv
